// ----- design/awvn_pkg.sv -----
// ----------------------------------------------------------------------------
// awvn_pkg
// Shared sizes, command codes and handshake structs of the vertex normal core.
// ----------------------------------------------------------------------------
`default_nettype none

package awvn_pkg;

  localparam int VERTICES = 1024;
  localparam int ACC_BITS = 48;
  localparam int VIDX_W   = $clog2(VERTICES);
  localparam int IDX_W    = 10;
  localparam int COORD_W  = 16;
  localparam int VTX_W    = 3 * COORD_W;
  localparam int ACCV_W   = 3 * ACC_BITS;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int CROSS_W  = PROD_W + 1;
  localparam int NORM_W   = 16;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_TRI  = 2'd1,
    CMD_READ = 2'd2
  } cmd_t;

  typedef struct packed {
    logic start;
    logic ack;
  } norm_ctl_t;

  typedef struct packed {
    logic valid;
    logic zero_length;
  } norm_stat_t;

endpackage

`default_nettype wire

// ----- design/awvn_ram.sv -----
// ----------------------------------------------------------------------------
// awvn_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module awvn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- design/awvn_norm.sv -----
// ----------------------------------------------------------------------------
// awvn_norm
// Iterative normalizer: range shift, sum of squares, bit-serial square root
// and a shared restoring divider that scales each component to Q1.14.
// ----------------------------------------------------------------------------
`default_nettype none

module awvn_norm import awvn_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire norm_ctl_t                  ctl,
  input  wire logic signed [ACC_BITS-1:0] sum_x,
  input  wire logic signed [ACC_BITS-1:0] sum_y,
  input  wire logic signed [ACC_BITS-1:0] sum_z,
  output norm_stat_t                      stat,
  output logic signed [NORM_W-1:0]        norm_x,
  output logic signed [NORM_W-1:0]        norm_y,
  output logic signed [NORM_W-1:0]        norm_z
);

  localparam int M_W    = 30;
  localparam int SQ_W   = 2 * M_W + 2;
  localparam int RT_W   = 64;
  localparam int R_W    = 32;
  localparam int DIV_W  = 46;
  localparam int Q_W    = 15;

  typedef enum logic [2:0] {
    N_IDLE, N_SHIFT, N_SQ, N_ROOT, N_DLOAD, N_DIV, N_DONE
  } nstate_t;

  nstate_t                   state_r;
  logic [ACC_BITS-1:0]       mx_r, my_r, mz_r;
  logic [2:0]                neg_r;
  logic                      zero_r;
  logic [4:0]                cnt_r;
  logic [1:0]                ci_r;
  logic [SQ_W-1:0]           ssq_r;
  logic [RT_W-1:0]           rem_r, res_r, bit_r;
  logic [DIV_W-1:0]          drem_r, dsh_r;
  logic [Q_W-1:0]            dq_r;
  logic signed [NORM_W-1:0]  nx_r, ny_r, nz_r;

  logic [ACC_BITS-1:0] top, msel;
  logic [1:0]          sel;
  logic [M_W-1:0]      m30;
  logic [SQ_W-1:0]     sq;
  logic [RT_W-1:0]     rt_sum;
  logic                div_ge;
  logic [Q_W-1:0]      q_fin;
  logic [NORM_W-1:0]   q_signed;
  logic [R_W-1:0]      root;

  always_comb begin
    top = mx_r;
    if (my_r > top) begin
      top = my_r;
    end
    if (mz_r > top) begin
      top = mz_r;
    end
    sel = (state_r == N_SQ) ? cnt_r[1:0] : ci_r;
    case (sel)
      2'd0:    msel = mx_r;
      2'd1:    msel = my_r;
      default: msel = mz_r;
    endcase
    m30      = msel[M_W-1:0];
    sq       = SQ_W'(m30) * SQ_W'(m30);
    rt_sum   = res_r + bit_r;
    root     = res_r[R_W-1:0];
    div_ge   = (drem_r >= dsh_r);
    q_fin    = {dq_r[Q_W-2:0], div_ge};
    q_signed = neg_r[ci_r] ? NORM_W'(-{1'b0, q_fin}) : {1'b0, q_fin};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      cnt_r   <= '0;
      ci_r    <= '0;
    end else begin
      case (state_r)
        N_IDLE: begin
          if (ctl.start) begin
            mx_r    <= sum_x[ACC_BITS-1] ? ACC_BITS'(-sum_x) : sum_x;
            my_r    <= sum_y[ACC_BITS-1] ? ACC_BITS'(-sum_y) : sum_y;
            mz_r    <= sum_z[ACC_BITS-1] ? ACC_BITS'(-sum_z) : sum_z;
            neg_r   <= {sum_z[ACC_BITS-1], sum_y[ACC_BITS-1], sum_x[ACC_BITS-1]};
            state_r <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          if (top == '0) begin
            zero_r  <= 1'b1;
            nx_r    <= '0;
            ny_r    <= '0;
            nz_r    <= '0;
            state_r <= N_DONE;
          end else if (|top[ACC_BITS-1:M_W]) begin
            mx_r <= mx_r >> 1;
            my_r <= my_r >> 1;
            mz_r <= mz_r >> 1;
          end else begin
            zero_r  <= 1'b0;
            ssq_r   <= '0;
            cnt_r   <= '0;
            state_r <= N_SQ;
          end
        end
        N_SQ: begin
          ssq_r <= ssq_r + sq;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd2) begin
            rem_r   <= RT_W'(ssq_r + sq);
            res_r   <= '0;
            bit_r   <= RT_W'(1) << (RT_W - 2);
            cnt_r   <= '0;
            state_r <= N_ROOT;
          end
        end
        N_ROOT: begin
          if (rem_r >= rt_sum) begin
            rem_r <= rem_r - rt_sum;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            ci_r    <= '0;
            state_r <= N_DLOAD;
          end
        end
        N_DLOAD: begin
          drem_r  <= DIV_W'({m30, 14'b0}) + DIV_W'(root >> 1);
          dsh_r   <= DIV_W'(root) << 14;
          dq_r    <= '0;
          cnt_r   <= '0;
          state_r <= N_DIV;
        end
        N_DIV: begin
          if (div_ge) begin
            drem_r <= drem_r - dsh_r;
          end
          dsh_r <= dsh_r >> 1;
          dq_r  <= q_fin;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(Q_W - 1)) begin
            case (ci_r)
              2'd0:    nx_r <= q_signed;
              2'd1:    ny_r <= q_signed;
              default: nz_r <= q_signed;
            endcase
            if (ci_r == 2'd2) begin
              state_r <= N_DONE;
            end else begin
              ci_r    <= ci_r + 2'd1;
              state_r <= N_DLOAD;
            end
          end
        end
        N_DONE: begin
          if (ctl.ack) begin
            state_r <= N_IDLE;
          end
        end
        default: state_r <= N_IDLE;
      endcase
    end
  end

  assign stat.valid       = (state_r == N_DONE);
  assign stat.zero_length = zero_r;
  assign norm_x = nx_r;
  assign norm_y = ny_r;
  assign norm_z = nz_r;

endmodule

`default_nettype wire

// ----- design/area_weighted_vertex_normals_core.sv -----
// ----------------------------------------------------------------------------
// area_weighted_vertex_normals_core
// Vertex store and per-vertex normal accumulator memories with triangle
// cross products and unit-length readout.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    command, indices, coordinates
//   out_     output     out_valid/out_ready  index, Q1.14 normal, zero flag
//
// A load writes the vertex store; a triangle does three vertex reads on the
// single read port, multiply, subtract, then a read and a write of the
// accumulator memory per corner. A read of a zero sum ends after the range
// shift; otherwise the range shift, the sum of squares, the square root and
// the divider, once per component, run in that order.
// After reset every accumulator entry is cleared before in_ready rises.
// A stalled result stalls only the next read; loads and triangles go on.
// ----------------------------------------------------------------------------
`default_nettype none

module area_weighted_vertex_normals_core import awvn_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                in_command,
  input  wire logic [IDX_W-1:0]          in_vertex_index,
  input  wire logic [IDX_W-1:0]          in_corner_b,
  input  wire logic [IDX_W-1:0]          in_corner_c,
  input  wire logic signed [COORD_W-1:0] in_coord_x,
  input  wire logic signed [COORD_W-1:0] in_coord_y,
  input  wire logic signed [COORD_W-1:0] in_coord_z,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [IDX_W-1:0]               out_normal_index,
  output logic signed [NORM_W-1:0]       out_normal_x,
  output logic signed [NORM_W-1:0]       out_normal_y,
  output logic signed [NORM_W-1:0]       out_normal_z,
  output logic                           out_zero_length
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_TRI_B, S_TRI_C, S_TRI_CAP, S_MUL, S_SUB,
    S_ACC_RD, S_ACC_WR, S_RD_WAIT, S_RD_NORM
  } state_t;

  function automatic logic signed [DIFF_W-1:0] sx(input logic [COORD_W-1:0] v);
    return {v[COORD_W-1], v};
  endfunction

  function automatic logic [ACC_BITS-1:0] sat_add(input logic [ACC_BITS-1:0] a,
                                                  input logic signed [CROSS_W-1:0] n);
    logic [ACC_BITS:0] s;
    s = {a[ACC_BITS-1], a} + (ACC_BITS+1)'(n);
    if (s[ACC_BITS] != s[ACC_BITS-1]) begin
      return s[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
    end
    return s[ACC_BITS-1:0];
  endfunction

  state_t                     state_r;
  logic [VIDX_W-1:0]          clr_cnt_r;
  logic [VIDX_W-1:0]          ia_r, ib_r, ic_r;
  logic [IDX_W-1:0]           ridx_r;
  logic                       rok_r;
  logic [1:0]                 k_r;
  logic [VTX_W-1:0]           va_r;
  logic signed [DIFF_W-1:0]   dbx_r, dby_r, dbz_r, dcx_r, dcy_r, dcz_r;
  logic signed [PROD_W-1:0]   p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic signed [CROSS_W-1:0]  nx_r, ny_r, nz_r;
  logic                       out_valid_r;
  logic [IDX_W-1:0]           oidx_r;
  logic signed [NORM_W-1:0]   ox_r, oy_r, oz_r;
  logic                       ozero_r;

  logic                       accept, in_ok, take_out;
  logic                       vs_we, acc_we;
  logic [VIDX_W-1:0]          vs_raddr, acc_raddr, acc_waddr, corner;
  logic [VTX_W-1:0]           vs_rdata;
  logic [ACCV_W-1:0]          acc_wdata, acc_rdata;
  norm_ctl_t                  nctl;
  norm_stat_t                 nstat;
  logic signed [ACC_BITS-1:0] nsum_x, nsum_y, nsum_z;
  logic signed [NORM_W-1:0]   nrm_x, nrm_y, nrm_z;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_ok    = (int'(in_vertex_index) < VERTICES);
  assign take_out = (state_r == S_RD_NORM) && nstat.valid && (!out_valid_r || out_ready);

  always_comb begin
    case (k_r)
      2'd0:    corner = ia_r;
      2'd1:    corner = ib_r;
      default: corner = ic_r;
    endcase
    case (state_r)
      S_TRI_B: vs_raddr = ib_r;
      S_TRI_C: vs_raddr = ic_r;
      default: vs_raddr = VIDX_W'(in_vertex_index);
    endcase
    vs_we     = accept && (in_command == CMD_LOAD) && in_ok;
    acc_raddr = (state_r == S_ACC_RD) ? corner : VIDX_W'(in_vertex_index);
    acc_we    = 1'b0;
    acc_waddr = VIDX_W'(in_vertex_index);
    acc_wdata = '0;
    case (state_r)
      S_CLEAR: begin
        acc_we    = 1'b1;
        acc_waddr = clr_cnt_r;
      end
      S_ACC_WR: begin
        acc_we    = 1'b1;
        acc_waddr = corner;
        acc_wdata = {sat_add(acc_rdata[3*ACC_BITS-1:2*ACC_BITS], nz_r),
                     sat_add(acc_rdata[2*ACC_BITS-1:ACC_BITS], ny_r),
                     sat_add(acc_rdata[ACC_BITS-1:0], nx_r)};
      end
      default: acc_we = vs_we;
    endcase
    nctl.start = (state_r == S_RD_WAIT);
    nctl.ack   = take_out;
    nsum_x = rok_r ? acc_rdata[ACC_BITS-1:0] : '0;
    nsum_y = rok_r ? acc_rdata[2*ACC_BITS-1:ACC_BITS] : '0;
    nsum_z = rok_r ? acc_rdata[3*ACC_BITS-1:2*ACC_BITS] : '0;
  end

  awvn_ram #(.WIDTH(VTX_W), .DEPTH(VERTICES)) u_vtx_ram (
    .clk   (clk),
    .we    (vs_we),
    .waddr (VIDX_W'(in_vertex_index)),
    .wdata ({in_coord_z, in_coord_y, in_coord_x}),
    .raddr (vs_raddr),
    .rdata (vs_rdata)
  );

  awvn_ram #(.WIDTH(ACCV_W), .DEPTH(VERTICES)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  awvn_norm u_norm (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (nctl),
    .sum_x  (nsum_x),
    .sum_y  (nsum_y),
    .sum_z  (nsum_z),
    .stat   (nstat),
    .norm_x (nrm_x),
    .norm_y (nrm_y),
    .norm_z (nrm_z)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take_out) begin
        out_valid_r <= 1'b1;
        oidx_r      <= ridx_r;
        ox_r        <= nrm_x;
        oy_r        <= nrm_y;
        oz_r        <= nrm_z;
        ozero_r     <= nstat.zero_length;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == VIDX_W'(VERTICES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          ia_r   <= VIDX_W'(in_vertex_index);
          ib_r   <= VIDX_W'(in_corner_b);
          ic_r   <= VIDX_W'(in_corner_c);
          ridx_r <= in_vertex_index;
          rok_r  <= in_ok;
          k_r    <= '0;
          if (accept) begin
            case (in_command)
              CMD_TRI: begin
                if (in_ok && int'(in_corner_b) < VERTICES && int'(in_corner_c) < VERTICES) begin
                  state_r <= S_TRI_B;
                end
              end
              CMD_READ: state_r <= S_RD_WAIT;
              default:  state_r <= S_IDLE;
            endcase
          end
        end
        S_TRI_B: begin
          va_r    <= vs_rdata;
          state_r <= S_TRI_C;
        end
        S_TRI_C: begin
          dbx_r   <= sx(vs_rdata[COORD_W-1:0]) - sx(va_r[COORD_W-1:0]);
          dby_r   <= sx(vs_rdata[2*COORD_W-1:COORD_W]) - sx(va_r[2*COORD_W-1:COORD_W]);
          dbz_r   <= sx(vs_rdata[3*COORD_W-1:2*COORD_W]) - sx(va_r[3*COORD_W-1:2*COORD_W]);
          state_r <= S_TRI_CAP;
        end
        S_TRI_CAP: begin
          dcx_r   <= sx(vs_rdata[COORD_W-1:0]) - sx(va_r[COORD_W-1:0]);
          dcy_r   <= sx(vs_rdata[2*COORD_W-1:COORD_W]) - sx(va_r[2*COORD_W-1:COORD_W]);
          dcz_r   <= sx(vs_rdata[3*COORD_W-1:2*COORD_W]) - sx(va_r[3*COORD_W-1:2*COORD_W]);
          state_r <= S_MUL;
        end
        S_MUL: begin
          p0_r    <= dby_r * dcz_r;
          p1_r    <= dbz_r * dcy_r;
          p2_r    <= dbz_r * dcx_r;
          p3_r    <= dbx_r * dcz_r;
          p4_r    <= dbx_r * dcy_r;
          p5_r    <= dby_r * dcx_r;
          state_r <= S_SUB;
        end
        S_SUB: begin
          nx_r    <= CROSS_W'(p0_r) - CROSS_W'(p1_r);
          ny_r    <= CROSS_W'(p2_r) - CROSS_W'(p3_r);
          nz_r    <= CROSS_W'(p4_r) - CROSS_W'(p5_r);
          state_r <= S_ACC_RD;
        end
        S_ACC_RD: state_r <= S_ACC_WR;
        S_ACC_WR: begin
          k_r     <= k_r + 2'd1;
          state_r <= (k_r == 2'd2) ? S_IDLE : S_ACC_RD;
        end
        S_RD_WAIT: state_r <= S_RD_NORM;
        S_RD_NORM: begin
          if (take_out) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_normal_index = oidx_r;
  assign out_normal_x     = ox_r;
  assign out_normal_y     = oy_r;
  assign out_normal_z     = oz_r;
  assign out_zero_length  = ozero_r;

  a_out_from_norm: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RD_NORM))
    else $error("result appeared without a finished normalization");

  a_norm_owned: assert property (@(posedge clk) disable iff (!rst_n)
    nstat.valid |-> (state_r == S_RD_NORM))
    else $error("normalizer result pending outside the read sequence");

  a_acc_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC_WR) |-> $past(state_r == S_ACC_RD))
    else $error("accumulator write without a preceding read");

  a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r == S_CLEAR) && state_r != S_CLEAR) |->
      $past(clr_cnt_r == VIDX_W'(VERTICES - 1)))
    else $error("clearing pass ended early");

endmodule

`default_nettype wire
